// File: rtl/skt_pkg.sv
// Package with the shared widths, codes and types of the sorted key table.
package skt_pkg;

  localparam int KEY_W   = 112;
  localparam int HI_W    = 64;
  localparam int LO_W    = 48;
  localparam int INDEX_W = 7;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 8;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // Function codes of an input item.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } skt_state_t;

endpackage

// File: rtl/skt_if.sv
// Handshake interfaces for the input items and the result items.
interface skt_in_if;
  import skt_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [INDEX_W-1:0] index;
  logic [HI_W-1:0]    key_hi;
  logic [LO_W-1:0]    key_lo;

  modport source (output valid, output func, output index, output key_hi, output key_lo,
                  input ready);
  modport sink   (input valid, input func, input index, input key_hi, input key_lo,
                  output ready);
endinterface

interface skt_out_if;
  import skt_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

// File: rtl/sorted_key_table_binary_search_top.sv
// Top level of the sorted key table with binary search over a synchronous key memory.
// A write item is stored at the accepting edge and gives no item out.
// A search item probes one table entry per cycle through the single memory read port:
// up to floor(log2(count)) + 1 probes (none when the count is zero), then the done state
// loads the output register once it is free, and the next item is taken back in idle.
// Reset clears the sequencer, the output valid flag and entry_count.

// The block is split into three parts. The register block holds entry_count behind an
// APB-style port whose pready is always high. The key memory holds TABLE_DEPTH keys of
// 112 bits with a registered read. The sequencer canonicalizes each incoming
// key, writes it on a write item, and on a search item walks the half-open range
// [0, count) one probe per cycle. The key table itself is not cleared by reset.
//
// The read address for the next probe is formed in the same cycle as the compare of the
// current probe, so the memory is never idle during a search. Writes are only taken while
// the sequencer is idle, so a search can never read an entry that is being written in the
// same cycle; this interlock replaces any forwarding path.
//
// The result item sits in its own output register, so a new item is accepted as soon as
// the sequencer returns to idle, even while the previous result still waits downstream.
module sorted_key_table_binary_search_top #(
  parameter int TABLE_DEPTH = 128,
  parameter int KEY_BYTES   = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  skt_in_if.sink                     req,
  skt_out_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [skt_pkg::ADDR_W-1:0]  paddr,
  input  logic [skt_pkg::DATA_W-1:0]  pwdata,
  output logic [skt_pkg::DATA_W-1:0]  prdata,
  output logic                       pready
);
  import skt_pkg::*;

  // Memory address width; one bit at least so a one-entry table still works.
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [COUNT_W-1:0] entry_count;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [KEY_W-1:0]   mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [KEY_W-1:0]   mem_rdata;

  skt_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .entry_count (entry_count)
  );

  skt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  skt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .entry_count (entry_count),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

endmodule

// File: rtl/skt_mem.sv
// Key table memory with one write port and one registered read port.
module skt_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [skt_pkg::KEY_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic [skt_pkg::KEY_W-1:0] rdata
);
  import skt_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/skt_cfg.sv
// APB register block holding the entry count.
module skt_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [skt_pkg::ADDR_W-1:0]  paddr,
  input  logic [skt_pkg::DATA_W-1:0]  pwdata,
  output logic [skt_pkg::DATA_W-1:0]  prdata,
  output logic                       pready,
  output logic [skt_pkg::COUNT_W-1:0] entry_count
);
  import skt_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (wr_en && paddr[2] == REG_ENTRY_COUNT) begin
      entry_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_ENTRY_COUNT) begin
      prdata = DATA_W'(entry_count);
    end else begin
      prdata = '0;
    end
  end

endmodule

// File: rtl/skt_ctrl.sv
// Search sequencer: key canonicalizing, probe loop over the table and result register.
module skt_ctrl #(
  parameter int TABLE_DEPTH = 128,
  parameter int KEY_BYTES   = 14,
  parameter int AW          = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  skt_in_if.sink                      req,
  skt_out_if.source                   rsp,
  input  logic [skt_pkg::COUNT_W-1:0] entry_count,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [skt_pkg::KEY_W-1:0]   mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  logic [skt_pkg::KEY_W-1:0]   mem_rdata
);
  import skt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int RW = INDEX_W + CW;
  localparam int NBYTES = KEY_W / 8;

  // Zero every byte after the first zero byte and every byte past the key length.
  function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             ended;
    r     = k;
    ended = 1'b0;
    for (int j = 0; j < NBYTES; j++) begin
      if (j >= KEY_BYTES) begin
        ended = 1'b1;
      end
      if (ended) begin
        r[KEY_W-1-8*j -: 8] = 8'h00;
      end else if (k[KEY_W-1-8*j -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

  // Index modulo the table depth by restoring compare and subtract.
  function automatic logic [AW-1:0] wrap_index(input logic [INDEX_W-1:0] idx);
    logic [RW-1:0] r;
    r = RW'(idx);
    for (int i = INDEX_W - 1; i >= 0; i--) begin
      if (r >= (RW'(TABLE_DEPTH) << i)) begin
        r = r - (RW'(TABLE_DEPTH) << i);
      end
    end
    return AW'(r);
  endfunction

  // Floor midpoint of the half-open range [a, b); b is above a.
  function automatic logic [AW-1:0] midpoint(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW + 1)'(a) + (CW + 1)'(b) - (CW + 1)'(1);
    return AW'(s >> 1);
  endfunction

  skt_state_t       state, state_next;
  logic [KEY_W-1:0] key_c;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    lo, hi;
  logic [CW-1:0]    lo_next, hi_next;
  logic [CW-1:0]    cnt;
  logic [AW-1:0]    mid_r;
  logic [EW-1:0]    ec_ext;
  logic             accept;
  logic             is_search;
  logic             eq, lt, cont;
  logic             slot_free;
  logic             load_out;
  logic             res_found;
  logic [POS_W-1:0] res_pos;
  logic             out_valid;
  logic             out_found;
  logic [POS_W-1:0] out_pos;

  assign ec_ext = EW'(entry_count);
  assign cnt    = (ec_ext > EW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(ec_ext);

  assign accept    = req.valid & req.ready;
  assign is_search = (req.func == FUNC_SEARCH);
  assign key_c     = canon_key({req.key_hi, req.key_lo});

  assign mem_we    = accept & ~is_search;
  assign mem_waddr = wrap_index(req.index);
  assign mem_wdata = key_c;

  assign eq   = (mem_rdata == key_r);
  assign lt   = (mem_rdata < key_r);
  assign lo_next = lt ? (CW'(mid_r) + CW'(1)) : lo;
  assign hi_next = lt ? hi : CW'(mid_r);
  assign cont = ~eq & (lo_next < hi_next);

  assign slot_free = ~out_valid | rsp.ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_search) begin
          state_next = (cnt == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!cont) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req.ready = 1'b0;
    load_out  = 1'b0;
    mem_raddr = midpoint(lo_next, hi_next);
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        mem_raddr = midpoint('0, cnt);
      end
      ST_PROBE: begin
        mem_raddr = midpoint(lo_next, hi_next);
      end
      ST_DONE: begin
        load_out = slot_free;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && is_search) begin
      key_r     <= key_c;
      lo        <= '0;
      hi        <= cnt;
      mid_r     <= mem_raddr;
      res_found <= 1'b0;
      res_pos   <= '0;
    end else if (state == ST_PROBE) begin
      lo    <= lo_next;
      hi    <= hi_next;
      mid_r <= mem_raddr;
      if (eq) begin
        res_found <= 1'b1;
        res_pos   <= POS_W'(mid_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found <= res_found;
      out_pos   <= res_pos;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.found    = out_found;
  assign rsp.position = out_pos;

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_IDLE))
    else $error("table write outside idle");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (lo < hi) && (CW'(mid_r) >= lo) && (CW'(mid_r) < hi))
    else $error("probe index outside search range");

  a_search_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && is_search) |=> (state != ST_IDLE))
    else $error("search item did not start a search");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && slot_free) |=> (rsp.valid && state == ST_IDLE))
    else $error("finished search not moved to the output register");

endmodule
